// File: rtl/core/gvn_pkg.sv
`default_nettype none
package gvn_pkg;

	localparam int POS_W   = 24;
	localparam int NORM_W  = 52;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 16;
	localparam int GCOLS_W = 11;

	// register index, taken from paddr[2]
	localparam logic REG_GRID_COLS = 1'b0;
	localparam logic REG_GRID_ROWS = 1'b1;

	localparam logic [GCOLS_W-1:0] GRID_COLS_RST = 11'd1024;
	localparam logic [ROW_W-1:0]   GRID_ROWS_RST = 16'd1024;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} vtx_t;

	typedef struct packed {
		logic [COL_W-1:0]         vert_col;
		logic [ROW_W-1:0]         vert_row;
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
		logic                     run_end;
		logic                     grid_end;
	} nrm_t;

	// classification of one vertex, made at accept time
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             row0;
		logic             col0;
		logic             last_col;
		logic             last_row;
		logic             up_edge;
	} gvn_flags_t;

	localparam int FLAGS_W = $bits(gvn_flags_t);

endpackage
`default_nettype wire

// File: rtl/core/gvn_fifo.sv
`default_nettype none
module gvn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic             full
);

	// depth is a power of two so the pointers wrap on their own
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] fifo_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign dout  = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/gvn_front.sv
`default_nettype none
module gvn_front import gvn_pkg::*; #(
	parameter int MAX_COLS   = 1024,
	parameter int COORD_BITS = 24,
	localparam int XW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int DW     = COORD_BITS + 1,
	localparam int WORK_W = 12 * DW + XW + FLAGS_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [GCOLS_W-1:0] grid_cols,
	input  logic [ROW_W-1:0]   grid_rows,
	input  logic               vtx_valid,
	output logic               vtx_stall,
	input  vtx_t               vtx,
	output logic               push,
	output logic [WORK_W-1:0]  work,
	input  logic               full
);

	localparam int CB = COORD_BITS;
	localparam logic [15:0] MAXC = 16'(MAX_COLS);

	logic [15:0]       cols_eff, rows_eff;
	logic [ROW_W-1:0]  row_q, row_m1;
	logic [XW-1:0]     col_q, col_s1;
	logic              last_col, last_row, up_edge, accept, f1_v_q;
	logic [3*CB-1:0]   vmem [MAX_COLS];
	logic [3*CB-1:0]   cur_w, cur_s1, b_s1, left_s1, left_q, a_q;
	gvn_flags_t        flags_c, flags_s1;

	function automatic logic [CB-1:0] to_coord(input logic [POS_W-1:0] p);
		logic [POS_W+CB-1:0] wide;
		wide = {{CB{1'b0}}, p};
		return wide[CB-1:0];
	endfunction

	function automatic logic [DW-1:0] sub(input logic [CB-1:0] p, input logic [CB-1:0] q);
		return {p[CB-1], p} - {q[CB-1], q};
	endfunction

	always_comb begin
		cols_eff = 16'(grid_cols);
		if (cols_eff < 16'd2) begin
			cols_eff = 16'd2;
		end else if (cols_eff > MAXC) begin
			cols_eff = MAXC;
		end
		rows_eff = (grid_rows < 16'd2) ? 16'd2 : grid_rows;
		row_m1   = row_q - 16'd1;
		last_col = 16'(col_q) >= cols_eff - 16'd1;
		last_row = row_q >= rows_eff - 16'd1;
		up_edge  = (row_m1 == '0) || (row_m1 >= rows_eff - 16'd1);
	end

	assign cur_w = {to_coord(vtx.pos_z), to_coord(vtx.pos_y), to_coord(vtx.pos_x)};

	assign flags_c = '{row: row_q, row0: (row_q == '0), col0: (col_q == '0),
		last_col: last_col, last_row: last_row, up_edge: up_edge};

	assign vtx_stall = f1_v_q && full;
	assign accept    = vtx_valid && !vtx_stall;
	assign push      = f1_v_q && !full;

	// upper vertex line: read the old entry and store the new vertex in one access
	always_ff @(posedge clk) begin
		if (accept) begin
			b_s1        <= vmem[col_q];
			vmem[col_q] <= cur_w;
			cur_s1      <= cur_w;
			left_s1     <= left_q;
			col_s1      <= col_q;
			flags_s1    <= flags_c;
		end
		// the upper-left corner is the upper-right corner of the word before
		if (push) begin
			a_q <= b_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
			f1_v_q <= 1'b0;
		end else begin
			if (accept) begin
				left_q <= cur_w;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
			if (accept) begin
				f1_v_q <= 1'b1;
			end else if (push) begin
				f1_v_q <= 1'b0;
			end
		end
	end

	// edge differences u0, v0, u1, v1
	always_comb begin
		logic [CB-1:0] av, bv, lv, cv;
		work = '0;
		for (int j = 0; j < 3; j++) begin
			av = a_q[j*CB +: CB];
			bv = b_s1[j*CB +: CB];
			lv = left_s1[j*CB +: CB];
			cv = cur_s1[j*CB +: CB];
			work[(0*3+j)*DW +: DW] = sub(bv, av);
			work[(1*3+j)*DW +: DW] = sub(lv, av);
			work[(2*3+j)*DW +: DW] = sub(cv, lv);
			work[(3*3+j)*DW +: DW] = sub(cv, bv);
		end
		work[12*DW +: XW]         = col_s1;
		work[12*DW+XW +: FLAGS_W] = flags_s1;
	end

endmodule
`default_nettype wire

// File: rtl/core/gvn_back.sv
`default_nettype none
module gvn_back import gvn_pkg::*; #(
	parameter int MAX_COLS   = 1024,
	parameter int COORD_BITS = 24,
	localparam int XW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int DW     = COORD_BITS + 1,
	localparam int WORK_W = 12 * DW + XW + FLAGS_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORK_W-1:0] head,
	input  logic              empty,
	output logic              pop,
	output logic              nrm_valid,
	input  logic              nrm_stall,
	output nrm_t              nrm
);

	localparam int NW = NORM_W;

	logic signed [DW-1:0]   d [4][3];
	logic [XW-1:0]          x_h, x_s1, x_s2, xm1;
	gvn_flags_t             flags_h, flags_s1, flags_s2;
	logic signed [2*DW-1:0] pa_s1 [4][3];
	logic signed [2*DW-1:0] pb_s1 [4][3];
	logic [NW-1:0]          n_s2 [4][3];
	logic                   vld_s1, vld_s2, adv, last_emit, do_acc;

	logic [3*NW-1:0]        sum_mem [MAX_COLS];
	logic [3*NW-1:0]        rd_s1, rd_s2, up_old, wr_data;
	logic [XW-1:0]          wr_addr;
	logic                   wr_en, spill_set;

	logic [NW-1:0]          carry_up_q [3];
	logic [NW-1:0]          carry_lo_q [3];
	logic [NW-1:0]          spill_q [3];
	logic [XW-1:0]          spill_x_q;
	logic                   spill_v_q;

	logic [NW-1:0]          up_xm1 [3];
	logic [NW-1:0]          up_x [3];
	logic [NW-1:0]          lo_xm1 [3];
	logic [NW-1:0]          rn [4][3];
	logic [XW-1:0]          rc [4];
	logic [ROW_W-1:0]       rr [4];
	logic [1:0]             sel [4];
	logic [1:0]             sh0, sh1, sh2;
	logic [2:0]             cnt_c;

	logic [NW-1:0]          nrm_s3 [4][3];
	logic [XW-1:0]          col_s3 [4];
	logic [ROW_W-1:0]       row_s3 [4];
	logic [2:0]             cnt_s3;
	logic [1:0]             idx_q;
	logic                   grid_s3;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 3; j++) begin
				d[k][j] = head[(k*3+j)*DW +: DW];
			end
		end
		x_h     = head[12*DW +: XW];
		flags_h = head[12*DW+XW +: FLAGS_W];
	end

	// the whole back pipeline moves together when the output stage frees up
	assign nrm_valid = (cnt_s3 != 3'd0);
	assign last_emit = (3'(idx_q) == cnt_s3 - 3'd1);
	assign adv       = !nrm_valid || (!nrm_stall && last_emit);
	assign pop       = adv && !empty;
	assign do_acc    = adv && vld_s2;

	// four cross products, six multiplies each pair
	for (genvar gq = 0; gq < 4; gq++) begin : g_quad
		for (genvar gj = 0; gj < 3; gj++) begin : g_axis
			localparam int IA = (gq >= 2) ? 2 : 0;
			localparam int IB = (gq % 2 == 1) ? 3 : 1;
			localparam int J1 = (gj + 1) % 3;
			localparam int J2 = (gj + 2) % 3;
			always_ff @(posedge clk) begin
				if (pop) begin
					pa_s1[gq][gj] <= d[IA][J1] * d[IB][J2];
					pb_s1[gq][gj] <= d[IA][J2] * d[IB][J1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_s1     <= x_h;
			flags_s1 <= flags_h;
		end
		if (adv) begin
			x_s2     <= x_s1;
			flags_s2 <= flags_s1;
			for (int q = 0; q < 4; q++) begin
				for (int j = 0; j < 3; j++) begin
					n_s2[q][j] <= NW'(64'(pa_s1[q][j]) - 64'(pb_s1[q][j]));
				end
			end
		end
	end

	// sum line store; reads in flight pick up writes to the same column
	always_ff @(posedge clk) begin
		if (wr_en) begin
			sum_mem[wr_addr] <= wr_data;
		end
		if (pop) begin
			rd_s1 <= (wr_en && wr_addr == x_h) ? wr_data : sum_mem[x_h];
		end
		if (adv) begin
			rd_s2 <= (wr_en && wr_addr == x_s1) ? wr_data : rd_s1;
		end
	end

	always_comb begin
		up_old = (spill_v_q && spill_x_q == x_s2) ? {spill_q[2], spill_q[1], spill_q[0]} : rd_s2;
		xm1    = x_s2 - XW'(1);
		for (int j = 0; j < 3; j++) begin
			up_xm1[j] = carry_up_q[j] + n_s2[0][j];
			up_x[j]   = up_old[j*NW +: NW] + n_s2[1][j];
			lo_xm1[j] = carry_lo_q[j] + n_s2[2][j];
		end

		wr_en     = do_acc && (flags_s2.row0 || !flags_s2.col0);
		wr_addr   = flags_s2.row0 ? x_s2 : xm1;
		wr_data   = flags_s2.row0 ? '0 : {lo_xm1[2], lo_xm1[1], lo_xm1[0]};
		spill_set = do_acc && !flags_s2.row0 && !flags_s2.col0 && flags_s2.last_col;

		// doubling for edge columns and edge rows
		sh0 = 2'(x_s2 == XW'(1)) + 2'(flags_s2.up_edge);
		sh1 = 2'd1 + 2'(flags_s2.up_edge);
		sh2 = 2'(x_s2 == XW'(1)) + 2'd1;
		for (int j = 0; j < 3; j++) begin
			rn[0][j] = up_xm1[j] << sh0;
			rn[1][j] = up_x[j] << sh1;
			rn[2][j] = lo_xm1[j] << sh2;
			rn[3][j] = n_s2[3][j] << 2'd2;
		end
		rc[0] = xm1;
		rc[1] = x_s2;
		rc[2] = xm1;
		rc[3] = x_s2;
		rr[0] = flags_s2.row - 16'd1;
		rr[1] = flags_s2.row - 16'd1;
		rr[2] = flags_s2.row;
		rr[3] = flags_s2.row;

		// order: upper row first, then lower row, each by column
		sel[0] = 2'd0;
		sel[1] = flags_s2.last_col ? 2'd1 : 2'd2;
		sel[2] = 2'd2;
		sel[3] = 2'd3;
		if (vld_s2 && !flags_s2.row0 && !flags_s2.col0) begin
			cnt_c = 3'd1 + 3'(flags_s2.last_col) + 3'(flags_s2.last_row)
				+ 3'(flags_s2.last_col && flags_s2.last_row);
		end else begin
			cnt_c = 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_acc && !flags_s2.row0) begin
			for (int j = 0; j < 3; j++) begin
				if (flags_s2.col0) begin
					carry_up_q[j] <= up_old[j*NW +: NW];
					carry_lo_q[j] <= '0;
				end else begin
					carry_up_q[j] <= up_x[j];
					carry_lo_q[j] <= n_s2[3][j];
				end
			end
		end
		if (spill_set) begin
			spill_x_q <= x_s2;
			for (int j = 0; j < 3; j++) begin
				spill_q[j] <= n_s2[3][j];
			end
		end
		if (adv) begin
			grid_s3 <= flags_s2.last_col && flags_s2.last_row;
			for (int k = 0; k < 4; k++) begin
				col_s3[k] <= rc[sel[k]];
				row_s3[k] <= rr[sel[k]];
				for (int j = 0; j < 3; j++) begin
					nrm_s3[k][j] <= rn[sel[k]][j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			cnt_s3    <= 3'd0;
			idx_q     <= 2'd0;
			spill_v_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= pop;
				vld_s2 <= vld_s1;
				cnt_s3 <= cnt_c;
				idx_q  <= 2'd0;
			end else if (nrm_valid && !nrm_stall) begin
				idx_q <= idx_q + 2'd1;
			end
			// the last column of a row waits here until its sum is rewritten
			if (spill_set) begin
				spill_v_q <= 1'b1;
			end else if (wr_en && wr_addr == spill_x_q) begin
				spill_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		nrm.vert_col = COL_W'(col_s3[idx_q]);
		nrm.vert_row = row_s3[idx_q];
		nrm.norm_x   = nrm_s3[idx_q][0];
		nrm.norm_y   = nrm_s3[idx_q][1];
		nrm.norm_z   = nrm_s3[idx_q][2];
		nrm.run_end  = last_emit;
		nrm.grid_end = last_emit && grid_s3;
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_valid |-> (3'(idx_q) < cnt_s3))
		else $error("output index past word count");

	a_grid_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(nrm_valid && nrm.grid_end) |-> nrm.run_end)
		else $error("grid end not on last word of a run");

	a_spill_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && spill_set) |-> (wr_addr != x_s2))
		else $error("sum write and spill hit the same column");

	a_adv_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cnt_c == 3'd0) |=> !nrm_valid)
		else $error("output shown for a vertex with no result");

endmodule
`default_nettype wire

// File: rtl/core/grid_vertex_normals_unit.sv
`default_nettype none
// Smooth normals of a quad grid, streamed one vertex at a time.
// vtx channel: grid vertices in raster order, row 0 first, column 0 first in each row,
// signed Q12.12 coordinates. A word is taken when vtx_valid is high and vtx_stall low.
// nrm channel: up to four normal words per vertex, each four times the averaged normal
// in units of 2^-24, with its column and row; run_end marks the last word caused by
// one vertex, grid_end the last normal of the grid. Row 0 and column 0 vertices give
// no word. After the last vertex of the last row the next vertex starts a new grid.
// grid_cols and grid_rows are written over the APB port; the user must write them only
// while the block is idle; the block itself does not enforce this. Throughput is one
// vertex per cycle while nrm_stall is low; a vertex on the last column or last row holds
// the pipeline until each of its words is sent, since the output stage sends one word a cycle.
// A vertex passes the accept stage, queue, multiply, cross product and sum, output register.
// A four-word queue sits between the input stage and the arithmetic pipeline; while
// nrm_stall is high the pipeline holds and the queue fills, then vtx_stall rises.
// Reset clears the counters and the queue; the line stores need no clearing.
module grid_vertex_normals_unit import gvn_pkg::*; #(
	parameter int MAX_COLS   = 1024,
	parameter int COORD_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        vtx_valid,
	output logic        vtx_stall,
	input  vtx_t        vtx,
	output logic        nrm_valid,
	input  logic        nrm_stall,
	output nrm_t        nrm
);

	localparam int XW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DW     = COORD_BITS + 1;
	localparam int WORK_W = 12 * DW + XW + FLAGS_W;

	logic [GCOLS_W-1:0] grid_cols_q;
	logic [ROW_W-1:0]   grid_rows_q;
	logic               cfg_wr, push, pop, empty, full;
	logic [WORK_W-1:0]  work, head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= GRID_COLS_RST;
			grid_rows_q <= GRID_ROWS_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_GRID_COLS: grid_cols_q <= pwdata[GCOLS_W-1:0];
				REG_GRID_ROWS: grid_rows_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GRID_COLS: prdata = 32'(grid_cols_q);
			REG_GRID_ROWS: prdata = 32'(grid_rows_q);
			default:       prdata = '0;
		endcase
	end

	gvn_front #(.MAX_COLS(MAX_COLS), .COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_cols (grid_cols_q),
		.grid_rows (grid_rows_q),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.push      (push),
		.work      (work),
		.full      (full)
	);

	gvn_fifo #(.WIDTH(WORK_W), .DEPTH(4)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (work),
		.pop    (pop),
		.dout   (head),
		.empty  (empty),
		.full   (full)
	);

	gvn_back #(.MAX_COLS(MAX_COLS), .COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.nrm_valid (nrm_valid),
		.nrm_stall (nrm_stall),
		.nrm       (nrm)
	);

endmodule
`default_nettype wire
